// ===== sv/elliptical_orbit_point_unit_assert.svh =====
// assertion macros for the elliptical orbit point unit
// expects clk and rst_n in the scope of each use
`ifndef ELLIPTICAL_ORBIT_POINT_UNIT_ASSERT_SVH
`define ELLIPTICAL_ORBIT_POINT_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define EOP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define EOP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define EOP_ASSERT(label, prop, msg)
`define EOP_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== sv/eop_pkg.sv =====
// shared constants and types for the elliptical orbit point unit
// no dependencies
`default_nettype none
package eop_pkg;

    // pipeline depths
    localparam int LAT_SINE   = 20;
    localparam int DIV_STAGES = 33;
    localparam int VLD_LEN    = LAT_SINE + DIV_STAGES + 3;

    // sine routine constants
    localparam logic [14:0] QUARTER     = 15'd16384;
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
    localparam logic [30:0] ONE_Q30     = 31'd1073741824;
    localparam int unsigned TAYLOR_DIV [0:4] = '{110, 72, 42, 20, 6};

    // configuration register map
    localparam int CFG_INDEX_W = 3;
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FOCUS_X  = 3'd0,
        REG_FOCUS_Y  = 3'd1,
        REG_SEMI_MAJ = 3'd2,
        REG_ECC      = 3'd3,
        REG_ROTATION = 3'd4
    } cfg_reg_t;

endpackage
`default_nettype wire

// ===== sv/eop_sine.sv =====
// pipelined fixed-point sine, Q1.16 result from a 16-bit phase
// uses eop_pkg; advances when en is high
`default_nettype none
module eop_sine
    import eop_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               en,
    input  wire logic        [15:0] phase,
    output logic signed      [17:0] sine
);

    // quarter-wave fold
    logic [14:0] t_reg, t_next;
    logic        n0_reg;

    always_comb
    begin
        if (phase[14])
            t_next = 15'(QUARTER - {1'b0, phase[13:0]});
        else
            t_next = {1'b0, phase[13:0]};
    end

    // phase to radians in q30, then square
    logic [30:0] x1_reg, x1_next;
    logic        n1_reg;
    logic [31:0] x2_next;

    assign x1_next = 31'((46'(t_reg) * 46'(HALF_PI_Q30)) >> 14);
    assign x2_next = 32'((62'(x1_reg) * 62'(x1_reg)) >> 30);

    logic [30:0] xs   [0:5];
    logic [31:0] x2s  [0:5];
    logic [30:0] accs [0:5];
    logic        negs [0:5];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg   <= t_next;
            n0_reg  <= phase[15];
            x1_reg  <= x1_next;
            n1_reg  <= n0_reg;
            xs[0]   <= x1_reg;
            x2s[0]  <= x2_next;
            negs[0] <= n1_reg;
        end
    end

    assign accs[0] = ONE_Q30;

    // horner steps: multiply, reciprocal estimate, correction
    for (genvar k = 0; k < 5; k++)
    begin : g_step
        localparam int unsigned DIVISOR = TAYLOR_DIV[k];
        localparam logic [35:0] RECIP   = 36'((64'd1 << 36) / DIVISOR);

        logic [31:0] va_reg, va_next;
        logic [30:0] xa_reg;
        logic [31:0] x2a_reg;
        logic        na_reg;
        logic [31:0] q0_reg, q0_next;
        logic [31:0] vb_reg;
        logic [30:0] xb_reg;
        logic [31:0] x2b_reg;
        logic        nb_reg;
        logic [39:0] rem;
        logic [31:0] quo;
        logic [30:0] acc_next;

        assign va_next = 32'((63'(x2s[k]) * 63'(accs[k])) >> 30);
        assign q0_next = 32'((68'(va_reg) * 68'(RECIP)) >> 36);

        // estimate is low by at most one
        always_comb
        begin
            rem      = 40'(vb_reg) - 40'(q0_reg) * 40'(DIVISOR);
            quo      = q0_reg + 32'(rem >= 40'(DIVISOR));
            acc_next = 31'(32'(ONE_Q30) - quo);
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                va_reg    <= va_next;
                xa_reg    <= xs[k];
                x2a_reg   <= x2s[k];
                na_reg    <= negs[k];
                q0_reg    <= q0_next;
                vb_reg    <= va_reg;
                xb_reg    <= xa_reg;
                x2b_reg   <= x2a_reg;
                nb_reg    <= na_reg;
                accs[k+1] <= acc_next;
                xs[k+1]   <= xb_reg;
                x2s[k+1]  <= x2b_reg;
                negs[k+1] <= nb_reg;
            end
        end
    end

    // final multiply, round to q16, apply sign
    logic [30:0]        vf_reg, vf_next;
    logic               nf_reg;
    logic [16:0]        mag;
    logic signed [17:0] sine_reg, sine_next;

    assign vf_next = 31'((62'(xs[5]) * 62'(accs[5])) >> 30);

    always_comb
    begin
        mag = 17'((32'(vf_reg) + 32'd8192) >> 14);
        if (nf_reg)
            sine_next = -$signed({1'b0, mag});
        else
            sine_next = $signed({1'b0, mag});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vf_reg   <= vf_next;
            nf_reg   <= negs[5];
            sine_reg <= sine_next;
        end
    end

    assign sine = sine_reg;

endmodule
`default_nettype wire

// ===== sv/eop_divider.sv =====
// pipelined restoring divider, one quotient bit per stage
// uses eop_pkg; quotient must fit DIV_STAGES bits, side data rides along
`default_nettype none
module eop_divider
    import eop_pkg::*;
#(
    parameter int SIDE_W = 36
)
(
    input  wire logic              clk,
    input  wire logic              en,
    input  wire logic [65:0]       dividend,
    input  wire logic [32:0]       divisor,
    input  wire logic [SIDE_W-1:0] side_in,
    output logic      [32:0]       quotient,
    output logic      [SIDE_W-1:0] side_out
);

    logic [32:0]       rem_reg  [0:DIV_STAGES-1];
    logic [32:0]       lo_reg   [0:DIV_STAGES-1];
    logic [32:0]       q_reg    [0:DIV_STAGES-1];
    logic [32:0]       d_reg    [0:DIV_STAGES-1];
    logic [SIDE_W-1:0] side_reg [0:DIV_STAGES-1];

    for (genvar s = 0; s < DIV_STAGES; s++)
    begin : g_stage
        localparam int BIT = DIV_STAGES - 1 - s;

        logic [32:0]       rem_in, lo_in, q_in, d_in;
        logic [SIDE_W-1:0] side_in_s;
        logic [33:0]       trial;
        logic              ge;
        logic [32:0]       rem_next, q_next;

        if (s == 0)
        begin : g_first
            assign rem_in    = dividend[65:33];
            assign lo_in     = dividend[32:0];
            assign q_in      = '0;
            assign d_in      = divisor;
            assign side_in_s = side_in;
        end
        else
        begin : g_rest
            assign rem_in    = rem_reg[s-1];
            assign lo_in     = lo_reg[s-1];
            assign q_in      = q_reg[s-1];
            assign d_in      = d_reg[s-1];
            assign side_in_s = side_reg[s-1];
        end

        // shift in one dividend bit, subtract when it fits
        always_comb
        begin
            trial = {rem_in, lo_in[BIT]};
            ge    = trial >= {1'b0, d_in};
            if (ge)
                rem_next = 33'(trial - {1'b0, d_in});
            else
                rem_next = trial[32:0];
            q_next      = q_in;
            q_next[BIT] = ge;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s]  <= rem_next;
                lo_reg[s]   <= lo_in;
                q_reg[s]    <= q_next;
                d_reg[s]    <= d_in;
                side_reg[s] <= side_in_s;
            end
        end
    end

    assign quotient = q_reg[DIV_STAGES-1];
    assign side_out = side_reg[DIV_STAGES-1];

endmodule
`default_nettype wire

// ===== sv/elliptical_orbit_point_unit.sv =====
// Elliptical orbit point unit: angle in, point on a configured ellipse and radius out.
// Channels: input word angle on in_valid/in_stall, result word point_x, point_y,
// radius on out_valid/out_stall; a word moves when valid is high and stall low.
// Configuration: cfg_valid/cfg_ready with cfg_index 0..4 (focus x, focus y,
// semi-major axis, eccentricity, rotation) and cfg_data; cfg_ready is always high,
// other indexes are dropped. Write only while no word is in flight.
// Path: sine units, denominator registers, divider, product register, output register.
// Throughput: one word per cycle unless stalled; set by the 20-stage sine units
// and the 33-stage divider that advance together with the output register.
// The a*(1-e^2) numerator is recomputed from the registers continuously through
// ee_reg, kk_reg, pp_lo/pp_hi and num_reg, settling well before any word reaches it.
// Stall: while the output holds a word and out_stall is high, the whole pipeline
// freezes and in_stall is raised; nothing is dropped or repeated.
// Reset: asynchronous, active low; config and valid regs clear to zero, pipeline empties.
// Uses eop_pkg, eop_sine, eop_divider and the assertion macro header.
`default_nettype none
`include "elliptical_orbit_point_unit_assert.svh"
module elliptical_orbit_point_unit
    import eop_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [15:0]            angle,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic signed [34:0]          point_x,
    output logic signed [34:0]          point_y,
    output logic [32:0]                 radius,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [31:0]            cfg_data
);

    // configuration registers
    logic signed [31:0] focus_x_reg, focus_y_reg;
    logic [31:0]        semi_reg;
    logic [15:0]        ecc_reg, rot_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focus_x_reg <= '0;
            focus_y_reg <= '0;
            semi_reg    <= '0;
            ecc_reg     <= '0;
            rot_reg     <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_FOCUS_X:  focus_x_reg <= cfg_data;
                REG_FOCUS_Y:  focus_y_reg <= cfg_data;
                REG_SEMI_MAJ: semi_reg    <= cfg_data;
                REG_ECC:      ecc_reg     <= cfg_data[15:0];
                REG_ROTATION: rot_reg     <= cfg_data[15:0];
                default:      ;
            endcase
        end
    end

    // pipeline advance and valid chain
    logic                 en;
    logic [VLD_LEN-1:0]   vld_reg;
    logic                 out_valid_reg;

    assign en        = !out_valid_reg || !out_stall;
    assign in_stall  = !en;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= {vld_reg[VLD_LEN-2:0], in_valid};
            out_valid_reg <= vld_reg[VLD_LEN-1];
        end
    end

    // numerator a*(2^32 - e*e), split in two partial products
    logic [31:0] ee_reg;
    logic [32:0] kk_reg;
    logic [47:0] pp_lo_reg;
    logic [48:0] pp_hi_reg;
    logic [65:0] num_reg;

    always_ff @(posedge clk)
    begin
        ee_reg    <= 32'(ecc_reg) * 32'(ecc_reg);
        kk_reg    <= 33'(34'h1_0000_0000 - 34'(ee_reg));
        pp_lo_reg <= 48'(semi_reg) * 48'(kk_reg[15:0]);
        pp_hi_reg <= 49'(semi_reg) * 49'(kk_reg[32:16]);
        num_reg   <= 66'(pp_lo_reg) + (66'(pp_hi_reg) << 16);
    end

    // three sine units: cos(angle), cos(theta), sin(theta)
    logic [15:0]        theta;
    logic signed [17:0] cos_a, cos_t, sin_t;

    assign theta = angle + rot_reg;

    eop_sine u_cos_angle
    (
        .clk   (clk),
        .en    (en),
        .phase (angle + 16'(QUARTER)),
        .sine  (cos_a)
    );

    eop_sine u_cos_theta
    (
        .clk   (clk),
        .en    (en),
        .phase (theta + 16'(QUARTER)),
        .sine  (cos_t)
    );

    eop_sine u_sin_theta
    (
        .clk   (clk),
        .en    (en),
        .phase (theta),
        .sine  (sin_t)
    );

    // denominator 2^32 - e*cos and rounded dividend
    logic signed [34:0] ec_reg, ec_next;
    logic signed [17:0] ct1_reg, st1_reg;
    logic signed [35:0] den_wide;
    logic [32:0]        den_reg;
    logic [65:0]        dvd_reg;
    logic [35:0]        side_reg;

    assign ec_next  = 35'($signed({1'b0, ecc_reg})) * 35'(cos_a);
    assign den_wide = 36'sh1_0000_0000 - 36'(ec_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ec_reg   <= ec_next;
            ct1_reg  <= cos_t;
            st1_reg  <= sin_t;
            den_reg  <= den_wide[32:0];
            dvd_reg  <= num_reg + 66'(den_wide[32:1]);
            side_reg <= {ct1_reg, st1_reg};
        end
    end

    // radius division
    logic [32:0] quo;
    logic [35:0] side_out;

    eop_divider #(
        .SIDE_W (36)
    ) u_divider
    (
        .clk      (clk),
        .en       (en),
        .dividend (dvd_reg),
        .divisor  (den_reg),
        .side_in  (side_reg),
        .quotient (quo),
        .side_out (side_out)
    );

    // scale by trig, round ties up, add focus
    logic signed [51:0] px_prod_reg, py_prod_reg;
    logic [32:0]        rad_reg;
    logic signed [52:0] px_sum, py_sum;

    always_comb
    begin
        px_sum = (53'(px_prod_reg) + 53'sd32768) >>> 16;
        py_sum = (53'(py_prod_reg) + 53'sd32768) >>> 16;
        px_sum = px_sum + 53'(focus_x_reg);
        py_sum = py_sum + 53'(focus_y_reg);
    end

    logic signed [34:0] point_x_reg, point_y_reg;
    logic [32:0]        radius_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_prod_reg <= 52'($signed({1'b0, quo})) * 52'($signed(side_out[35:18]));
            py_prod_reg <= 52'($signed({1'b0, quo})) * 52'($signed(side_out[17:0]));
            rad_reg     <= quo;
            point_x_reg <= px_sum[34:0];
            point_y_reg <= py_sum[34:0];
            radius_reg  <= rad_reg;
        end
    end

    assign point_x = point_x_reg;
    assign point_y = point_y_reg;
    assign radius  = radius_reg;

    // checks
    `EOP_ASSERT_NEXT(a_freeze_holds_chain, !en, $stable(vld_reg) && $stable(out_valid_reg), "valid chain moved while frozen")
    `EOP_ASSERT(a_take_frees_input, (out_valid && !out_stall) |-> !in_stall, "input stalled after output word was taken")
    `EOP_ASSERT_NEXT(a_word_reaches_output, en && vld_reg[VLD_LEN-1], out_valid, "word lost at output register")

endmodule
`default_nettype wire

// ===== verif/elliptical_orbit_point_unit_test.sv =====
// testbench for elliptical_orbit_point_unit: a directed table and then random angles under
// random configurations, each result checked against a typed value or an orbit predictor
// depends on eop_pkg and the elliptical_orbit_point_unit rtl
`timescale 1ns / 1ps
module elliptical_orbit_point_unit_test;
    import eop_pkg::*;

    typedef struct {
        logic signed [34:0] px;
        logic signed [34:0] py;
        logic [32:0]        r;
    } orbit_point_t;

    typedef enum bit {ROW_CFG, ROW_ANGLE} row_kind_t;

    typedef struct {
        row_kind_t    kind;
        cfg_reg_t     idx;
        logic [31:0]  data;
        logic [15:0]  ang;
        bit           typed;
        orbit_point_t want;
    } stim_row_t;

    logic                   clk = 0;
    logic                   rst_n = 0;
    logic                   in_valid = 0;
    logic                   in_stall;
    logic [15:0]            angle = 0;
    logic                   out_valid;
    logic                   out_stall = 0;
    logic signed [34:0]     point_x;
    logic signed [34:0]     point_y;
    logic [32:0]            radius;
    logic                   cfg_valid = 0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_FOCUS_X;
    logic [31:0]            cfg_data = 0;

    // predictor copy of the register file
    logic signed [31:0] orb_fx, orb_fy;
    logic [31:0]        orb_a;
    logic [15:0]        orb_e, orb_rot;

    orbit_point_t pending_points[$];
    int  failures = 0;
    bit  calm = 0;
    bit  hold_req = 0;
    stim_row_t rows[$];

    elliptical_orbit_point_unit uut (.*);

    always #1 clk = ~clk;

    initial
    begin
        #2_000_000;
        $display("elliptical_orbit_point_unit test failed");
        $finish;
    end

    // sine of a quarter-wave phase, unsigned q16
    function automatic longint unsigned quarter_sin(input longint unsigned t);
        longint unsigned x, x2, acc, v;
        x   = (t * 64'd1686629713) >> 14;
        x2  = (x * x) >> 30;
        acc = 64'd1073741824 - x2 / 110;
        acc = 64'd1073741824 - ((x2 * acc) >> 30) / 72;
        acc = 64'd1073741824 - ((x2 * acc) >> 30) / 42;
        acc = 64'd1073741824 - ((x2 * acc) >> 30) / 20;
        acc = 64'd1073741824 - ((x2 * acc) >> 30) / 6;
        v   = (x * acc) >> 30;
        return (v + 8192) >> 14;
    endfunction

    function automatic longint turn_sin(input logic [15:0] p);
        longint mag;
        mag = p[14] ? longint'(quarter_sin(16384 - p[13:0])) : longint'(quarter_sin(p[13:0]));
        return p[15] ? -mag : mag;
    endfunction

    function automatic longint turn_cos(input logic [15:0] p);
        return turn_sin(p + 16'd16384);
    endfunction

    // round(r * trig / 65536), ties up
    function automatic longint scale_by_trig(input longint r, input longint trig);
        longint prod;
        prod = r * trig;
        return (prod + 32768) >>> 16;
    endfunction

    function automatic orbit_point_t orbit_point(input logic [15:0] ang);
        orbit_point_t res;
        bit [127:0] num, den, rad;
        longint ec, px, py;
        logic [15:0] theta;
        ec    = longint'({48'd0, orb_e}) * turn_cos(ang);
        num   = 128'(orb_a) * (128'h1_0000_0000 - 128'(orb_e) * 128'(orb_e));
        den   = 128'(64'sh1_0000_0000 - ec);
        rad   = (num + den / 2) / den;
        theta = ang + orb_rot;
        px    = longint'(orb_fx) + scale_by_trig(longint'(rad[63:0]), turn_cos(theta));
        py    = longint'(orb_fy) + scale_by_trig(longint'(rad[63:0]), turn_sin(theta));
        res.px = px[34:0];
        res.py = py[34:0];
        res.r  = rad[32:0];
        return res;
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] data);
        @(negedge clk);
        cfg_valid = 1;
        cfg_index = idx;
        cfg_data  = data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_FOCUS_X:  orb_fx  = data;
            REG_FOCUS_Y:  orb_fy  = data;
            REG_SEMI_MAJ: orb_a   = data;
            REG_ECC:      orb_e   = data[15:0];
            REG_ROTATION: orb_rot = data[15:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 0;
    endtask

    // offer one angle word; valid stays high into the next word when there is no gap
    task automatic send_angle(input logic [15:0] ang, input bit typed, input orbit_point_t want);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 17);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid = 0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1;
        angle    = ang;
        do @(posedge clk); while (in_stall);
        pending_points.push_back(typed ? want : orbit_point(ang));
    endtask

    // wait for every expected word (up to a timeout), then let the pipeline run empty
    task automatic drain;
        int waited;
        waited = 0;
        @(negedge clk);
        in_valid = 0;
        while (pending_points.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (VLD_LEN + 4) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 3))
            0: return 32'h0000_0000;
            1: return 32'hffff_ffff;
            2: return $urandom_range(0, 1000);
            default: return $urandom;
        endcase
    endfunction

    // output side: random stall before each word, one long hold on request
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            n = calm ? 0 : $urandom_range(0, 17);
            if (hold_req)
            begin
                n = 300;
                hold_req = 0;
            end
            if (n > 0)
            begin
                @(negedge clk);
                out_stall = 1;
                repeat (n) @(negedge clk);
                out_stall = 0;
            end
            do @(posedge clk); while (!(out_valid && !out_stall));
        end
    end

    // result checker
    always @(posedge clk)
    begin
        orbit_point_t exp_pt;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_points.size() == 0)
            begin
                $display("%0t: unexpected word x=%0d y=%0d r=%0d", $time, point_x, point_y,
                         radius);
                failures++;
            end
            else
            begin
                exp_pt = pending_points.pop_front();
                if (point_x !== exp_pt.px)
                begin
                    $display("%0t: point_x expected %0d got %0d", $time, exp_pt.px, point_x);
                    failures++;
                end
                if (point_y !== exp_pt.py)
                begin
                    $display("%0t: point_y expected %0d got %0d", $time, exp_pt.py, point_y);
                    failures++;
                end
                if (radius !== exp_pt.r)
                begin
                    $display("%0t: radius expected %0d got %0d", $time, exp_pt.r, radius);
                    failures++;
                end
            end
        end
    end

    function automatic stim_row_t cfg_row(input cfg_reg_t idx, input logic [31:0] data);
        stim_row_t row;
        row = '{ROW_CFG, idx, data, 16'd0, 1'b0, '{35'sd0, 35'sd0, 33'd0}};
        return row;
    endfunction

    function automatic stim_row_t ang_row(input logic [15:0] ang, input bit typed,
                                          input orbit_point_t want);
        stim_row_t row;
        row = '{ROW_ANGLE, REG_FOCUS_X, 32'd0, ang, typed, want};
        return row;
    endfunction

    initial
    begin
        orbit_point_t none, zero_pt;
        stim_row_t    row;
        int           n;
        none    = '{35'sd0, 35'sd0, 33'd0};
        zero_pt = none;
        orb_fx = 0; orb_fy = 0; orb_a = 0; orb_e = 0; orb_rot = 0;

        // directed table
        rows.push_back(ang_row(16'h0000, 1, zero_pt));
        rows.push_back(ang_row(16'hffff, 1, zero_pt));
        rows.push_back(cfg_row(REG_FOCUS_X, 32'h8000_0000));
        rows.push_back(cfg_row(REG_FOCUS_Y, 32'h7fff_ffff));
        rows.push_back(ang_row(16'd12345, 1, '{-35'sd2147483648, 35'sd2147483647, 33'd0}));
        rows.push_back(cfg_row(REG_FOCUS_X, 32'd0));
        rows.push_back(cfg_row(REG_FOCUS_Y, 32'd0));
        rows.push_back(cfg_row(REG_SEMI_MAJ, 32'hffff_ffff));
        rows.push_back(ang_row(16'h0000, 1, '{35'sd4294967295, 35'sd0, 33'd4294967295}));
        rows.push_back(ang_row(16'h4000, 0, none));
        rows.push_back(ang_row(16'h8000, 0, none));
        // eccentricity next to one
        rows.push_back(cfg_row(REG_ECC, 32'h0000_ffff));
        rows.push_back(ang_row(16'h0000, 0, none));
        rows.push_back(ang_row(16'h8000, 0, none));
        // angle plus rotation wraps
        rows.push_back(cfg_row(REG_ROTATION, 32'h0000_ffff));
        rows.push_back(ang_row(16'h0001, 0, none));
        rows.push_back(ang_row(16'hffff, 0, none));
        // unknown indexes are dropped, bits above a register width are dropped
        rows.push_back(cfg_row(cfg_reg_t'(3'd5), 32'h1234_5678));
        rows.push_back(cfg_row(cfg_reg_t'(3'd7), 32'hffff_ffff));
        rows.push_back(cfg_row(REG_ECC, 32'hffff_8000));
        rows.push_back(cfg_row(REG_ROTATION, 32'habcd_0000));
        rows.push_back(ang_row(16'h5555, 0, none));
        rows.push_back(ang_row(16'haaaa, 0, none));

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        foreach (rows[i])
        begin
            row = rows[i];
            if (row.kind == ROW_CFG)
            begin
                drain();
                write_reg(row.idx, row.data);
            end
            else
                send_angle(row.ang, row.typed, row.want);
        end

        // random phases, each under a fresh configuration
        for (int ph = 0; ph < 6; ph++)
        begin
            drain();
            write_reg(REG_FOCUS_X, pick_word());
            write_reg(REG_FOCUS_Y, pick_word());
            write_reg(REG_SEMI_MAJ, pick_word());
            write_reg(REG_ECC, pick_word());
            write_reg(REG_ROTATION, pick_word());
            calm = (ph == 2);
            if (ph == 4)
            begin
                calm = 1;
                hold_req = 1;
            end
            n = (ph == 2 || ph == 4) ? 60 : 85;
            repeat (n)
                send_angle(16'($urandom), 0, none);
            calm = 0;
        end

        drain();
        if (failures == 0 && pending_points.size() == 0)
            $display("elliptical_orbit_point_unit test passed");
        else
            $display("elliptical_orbit_point_unit test failed");
        $finish;
    end
endmodule

// ===== elliptical_orbit_point_unit.f =====
+incdir+sv
sv/eop_pkg.sv
sv/eop_sine.sv
sv/eop_divider.sv
sv/elliptical_orbit_point_unit.sv
verif/elliptical_orbit_point_unit_test.sv
